@@ src/tts_pkg.sv @@
// Shared types and codes for the timer task table.
package tts_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [1:0] KIND_ADD     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] now_ms;
        logic [31:0] period_ms;
        logic [7:0]  task_tag;
        logic        repeat_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic       accepted;
        logic [3:0] slot;
        logic [7:0] task_tag_res;
        logic       last;
    } t_out_item;

endpackage

@@ src/tts_slot_mem.sv @@
// Slot storage: start time, interval, tag and repeat flag, one read port, one write port.
module tts_slot_mem #(
    parameter int SLOTS = 16,
    parameter int IW    = 4
) (
    input  logic          i_clk,
    input  logic [IW-1:0] i_rd_addr,
    input  logic [IW-1:0] i_wr_addr,
    input  logic          i_we_start,
    input  logic          i_we_cfg,
    input  logic [31:0]   i_wr_start,
    input  logic [31:0]   i_wr_interval,
    input  logic [7:0]    i_wr_tag,
    input  logic          i_wr_rep,
    output logic [31:0]   o_rd_start,
    output logic [31:0]   o_rd_interval,
    output logic [7:0]    o_rd_tag,
    output logic          o_rd_rep
);
    logic [31:0] r_start_mem [SLOTS];
    logic [31:0] r_intv_mem  [SLOTS];
    logic [7:0]  r_tag_mem   [SLOTS];
    logic        r_rep_mem   [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we_start) begin
            r_start_mem[i_wr_addr] <= i_wr_start;
        end
        if (i_we_cfg) begin
            r_intv_mem[i_wr_addr] <= i_wr_interval;
            r_tag_mem[i_wr_addr]  <= i_wr_tag;
            r_rep_mem[i_wr_addr]  <= i_wr_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_start    <= r_start_mem[i_rd_addr];
        o_rd_interval <= r_intv_mem[i_rd_addr];
        o_rd_tag      <= r_tag_mem[i_rd_addr];
        o_rd_rep      <= r_rep_mem[i_rd_addr];
    end
endmodule

@@ src/tts_cmp.sv @@
// Expiry compare: elapsed time modulo 2^32 against the slot interval.
module tts_cmp (
    input  logic [31:0] i_now,
    input  logic [31:0] i_start,
    input  logic [31:0] i_interval,
    output logic        o_expired
);
    logic [31:0] elapsed;

    assign elapsed   = i_now - i_start;
    assign o_expired = (elapsed >= i_interval);
endmodule

@@ src/timer_task_table.sv @@
// Timer task table: slot sequencer, used bits and output register.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): an add item takes the
// lowest free slot and answers with one kind 0 result; a tick item scans all
// slots and gives one kind 1 result per expired slot, or one kind 2 result
// when nothing expired. The final result of every item has last set.
// One item is worked on at a time; o_in_stall is high until its final result
// sits in the output register.
// The slot scan steps through one slot per cycle while the output register can
// take a result; a tick reads each slot through the single read port of the
// slot memory and the one subtract-compare unit.
// Output channel (o_out_valid / i_out_stall / o_out_item): results wait in a
// one-entry output register; while a result waits there and the receiver
// stalls, the scan pauses and no slot is updated.
// Reset clears every used bit, the sequencer and the output valid flag at once;
// the table is ready in the first cycle after reset.
module timer_task_table #(
    parameter int SLOTS = tts_pkg::SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  tts_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output tts_pkg::t_out_item o_out_item
);
    import tts_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_TICK = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IW-1:0]    r_idx, n_idx;
    t_in_item         r_item, n_item;
    logic [SLOTS-1:0] r_used, n_used;
    logic             r_pend_v, n_pend_v;
    t_out_item        r_pend, n_pend;
    logic             r_out_v, n_out_v;
    t_out_item        r_out, n_out;

    logic          out_free;
    logic          load_out;
    logic          last_idx;
    logic          hit;
    logic          expired;
    logic [IW-1:0] rd_addr;
    logic          we_start;
    logic          we_cfg;
    logic [31:0]   rd_start;
    logic [31:0]   rd_interval;
    logic [7:0]    rd_tag;
    logic          rd_rep;

    tts_slot_mem #(
        .SLOTS (SLOTS),
        .IW    (IW)
    ) u_mem (
        .i_clk         (i_clk),
        .i_rd_addr     (rd_addr),
        .i_wr_addr     (r_idx),
        .i_we_start    (we_start),
        .i_we_cfg      (we_cfg),
        .i_wr_start    (r_item.now_ms),
        .i_wr_interval (r_item.period_ms),
        .i_wr_tag      (r_item.task_tag),
        .i_wr_rep      (r_item.repeat_req),
        .o_rd_start    (rd_start),
        .o_rd_interval (rd_interval),
        .o_rd_tag      (rd_tag),
        .o_rd_rep      (rd_rep)
    );

    tts_cmp u_cmp (
        .i_now      (r_item.now_ms),
        .i_start    (rd_start),
        .i_interval (rd_interval),
        .o_expired  (expired)
    );

    assign out_free = !r_out_v || !i_out_stall;
    assign last_idx = (r_idx == IW'(SLOTS - 1));
    assign hit      = r_used[r_idx] && expired;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_item   = r_item;
        n_used   = r_used;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_out    = r_out;
        load_out = 1'b0;
        we_start = 1'b0;
        we_cfg   = 1'b0;
        rd_addr  = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                rd_addr = '0;
                if (i_in_valid) begin
                    n_item   = i_in_item;
                    n_idx    = '0;
                    n_pend_v = 1'b0;
                    n_state  = (i_in_item.cmd == CMD_TICK) ? ST_TICK : ST_ADD;
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    if (!r_used[r_idx]) begin
                        we_start      = 1'b1;
                        we_cfg        = 1'b1;
                        n_used[r_idx] = 1'b1;
                        load_out      = 1'b1;
                        n_out         = '{kind: KIND_ADD, accepted: 1'b1, slot: 4'(r_idx),
                                          task_tag_res: r_item.task_tag, last: 1'b1};
                        n_state       = ST_IDLE;
                    end else if (last_idx) begin
                        load_out = 1'b1;
                        n_out    = '{kind: KIND_ADD, accepted: 1'b0, slot: 4'd0,
                                     task_tag_res: r_item.task_tag, last: 1'b1};
                        n_state  = ST_IDLE;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    if (hit) begin
                        if (r_pend_v) begin
                            load_out = 1'b1;
                            n_out    = r_pend;
                        end
                        n_pend_v = 1'b1;
                        n_pend   = '{kind: KIND_EXPIRED, accepted: 1'b0, slot: 4'(r_idx),
                                     task_tag_res: rd_tag, last: 1'b0};
                        if (rd_rep) begin
                            we_start = 1'b1;
                        end else begin
                            n_used[r_idx] = 1'b0;
                        end
                    end
                    if (last_idx) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        rd_addr = r_idx + IW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_pend_v) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                    end else begin
                        n_out = '{kind: KIND_EMPTY, accepted: 1'b0, slot: 4'd0,
                                  task_tag_res: 8'd0, last: 1'b1};
                    end
                    n_pend_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load_out) begin
            n_out_v = 1'b1;
        end else if (!i_out_stall) begin
            n_out_v = 1'b0;
        end else begin
            n_out_v = r_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_item <= n_item;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;
endmodule

@@ src/tts_checker.sv @@
// Port-level checks for the timer task table, bound to the top level.
module tts_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input tts_pkg::t_out_item o_out_item
);
    import tts_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_out_valid) && $past(i_out_stall))
        |-> (o_out_valid && $stable(o_out_item)))
        else $error("output item changed while stalled");

    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == KIND_ADD) |-> o_out_item.last)
        else $error("add answer without last");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == KIND_EMPTY)
        |-> (o_out_item.last && !o_out_item.accepted && o_out_item.slot == 4'd0
             && o_out_item.task_tag_res == 8'd0))
        else $error("malformed empty tick result");

    a_expired_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.kind == KIND_EXPIRED) |-> !o_out_item.accepted)
        else $error("expired result with accepted set");
endmodule

bind timer_task_table tts_checker u_tts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ bench/tb_timer_task_table.sv @@
// Testbench for timer_task_table: directed and random add/tick items checked against a predictor.
module tb_timer_task_table;
    import tts_pkg::*;

    localparam int SLOTS = SLOTS_DEF;
    localparam int STALL_LIMIT = 4000;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;
    logic [31:0] clock_ms = 32'hFFFF_F800;

    // predicted table contents
    bit          slot_used [SLOTS];
    logic [31:0] start_time [SLOTS];
    logic [31:0] interval [SLOTS];
    logic [7:0]  tag_store [SLOTS];
    bit          repeat_store [SLOTS];
    t_out_item   timer_answers_q [$];

    timer_task_table #(.SLOTS(SLOTS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_in_item make_item(input logic cmd, input logic [31:0] now,
                                           input logic [31:0] per, input logic [7:0] tag,
                                           input logic rep);
        t_in_item it;
        it.cmd        = cmd;
        it.now_ms     = now;
        it.period_ms  = per;
        it.task_tag   = tag;
        it.repeat_req = rep;
        return it;
    endfunction

    task automatic advance_timer_table(input t_in_item it);
        t_out_item   r;
        logic [31:0] elapsed;
        int          fired;
        bit          placed;
        fired  = 0;
        placed = 0;
        if (it.cmd == CMD_ADD) begin
            r = '0;
            r.kind         = KIND_ADD;
            r.task_tag_res = it.task_tag;
            r.last         = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!placed && !slot_used[i]) begin
                    placed          = 1;
                    slot_used[i]    = 1;
                    start_time[i]   = it.now_ms;
                    interval[i]     = it.period_ms;
                    tag_store[i]    = it.task_tag;
                    repeat_store[i] = it.repeat_req;
                    r.accepted      = 1'b1;
                    r.slot          = 4'(i);
                end
            end
            timer_answers_q.push_back(r);
        end else begin
            for (int i = 0; i < SLOTS; i++) begin
                elapsed = it.now_ms - start_time[i];
                if (slot_used[i] && elapsed >= interval[i]) begin
                    r = '0;
                    r.kind         = KIND_EXPIRED;
                    r.slot         = 4'(i);
                    r.task_tag_res = tag_store[i];
                    timer_answers_q.push_back(r);
                    fired++;
                    if (repeat_store[i]) begin
                        start_time[i] = it.now_ms;
                    end else begin
                        slot_used[i]    = 0;
                        start_time[i]   = '0;
                        interval[i]     = '0;
                        tag_store[i]    = '0;
                        repeat_store[i] = 0;
                    end
                end
            end
            if (fired == 0) begin
                r = '0;
                r.kind = KIND_EMPTY;
                r.last = 1'b1;
            end else begin
                r = timer_answers_q.pop_back();
                r.last = 1'b1;
            end
            timer_answers_q.push_back(r);
        end
    endtask

    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        advance_timer_table(it);
    endtask

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (timer_answers_q.size() == 0) begin
                report("unexpected item", 32'(out_item), '0);
            end else begin
                want = timer_answers_q.pop_front();
                if (out_item.kind !== want.kind)
                    report("kind", 32'(out_item.kind), 32'(want.kind));
                if (out_item.accepted !== want.accepted)
                    report("accepted", 32'(out_item.accepted), 32'(want.accepted));
                if (out_item.slot !== want.slot)
                    report("slot", 32'(out_item.slot), 32'(want.slot));
                if (out_item.task_tag_res !== want.task_tag_res)
                    report("task_tag_res", 32'(out_item.task_tag_res), 32'(want.task_tag_res));
                if (out_item.last !== want.last)
                    report("last", 32'(out_item.last), 32'(want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_empty_tick;
        send_item(make_item(CMD_TICK, 32'h0, 32'hFFFF_FFFF, 8'hFF, 1'b1));
    endtask

    task automatic test_fill_table;
        logic [31:0] now;
        logic [31:0] per;
        logic [7:0]  tag;
        for (int i = 0; i < SLOTS; i++) begin
            now = (i == 1) ? 32'hFFFF_FFF0 : 32'(i * 7);
            case (i)
                0: per = 32'h0;
                1: per = 32'h20;
                2: per = 32'hFFFF_FFFF;
                3: per = 32'h8000_0000;
                default: per = 32'(i * 3);
            endcase
            tag = (i == 0) ? 8'h00 : (i == SLOTS - 1) ? 8'hFF : 8'(i * 17);
            send_item(make_item(CMD_ADD, now, per, tag, (i % 3) == 0));
        end
        // table full
        send_item(make_item(CMD_ADD, 32'h55, 32'h1, 8'hA5, 1'b1));
    endtask

    task automatic test_expiry_cases;
        send_item(make_item(CMD_TICK, 32'h10, 32'h0, 8'h0, 1'b0));
        send_item(make_item(CMD_TICK, 32'h8000_0010, 32'hFFFF_FFFF, 8'h3C, 1'b0));
        send_item(make_item(CMD_TICK, 32'hFFFF_FFFF, 32'h1234, 8'hC3, 1'b1));
        send_item(make_item(CMD_ADD, 32'hFFFF_FFFE, 32'h5, 8'h81, 1'b1));
        send_item(make_item(CMD_TICK, 32'h0000_0003, 32'h0, 8'h7E, 1'b0));
    endtask

    task automatic test_random_traffic(input int sidle, input int ridle, input int count);
        int roll;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                send_item(make_item(1'($urandom_range(1)), $urandom, $urandom,
                                    8'($urandom_range(255)), 1'($urandom_range(1))));
            end else begin
                clock_ms = clock_ms + $urandom_range(30);
                if (roll < 55)
                    send_item(make_item(CMD_ADD, clock_ms, $urandom_range(100),
                                        8'($urandom_range(255)), $urandom_range(99) < 10));
                else
                    send_item(make_item(CMD_TICK, clock_ms, $urandom,
                                        8'($urandom_range(255)), 1'($urandom_range(1))));
            end
        end
    endtask

    initial begin
        foreach (slot_used[i]) begin
            slot_used[i]    = 0;
            start_time[i]   = '0;
            interval[i]     = '0;
            tag_store[i]    = '0;
            repeat_store[i] = 0;
        end
        send_idle_pct = 21;
        recv_idle_pct = 69;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_tick();
        test_fill_table();
        test_expiry_cases();
        test_random_traffic(21, 69, 60);
        test_random_traffic(69, 21, 60);
        test_random_traffic(0, 0, 60);
        in_valid <= 1'b0;

        while (timer_answers_q.size() != 0) @(posedge i_clk);
        repeat (SLOTS + 4) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
